@@ hw/rtl/line_segment_intersection_top_macros.svh @@
// ----------------------------------------------------------------------------
// line_segment_intersection_top_macros
// assertion macros used by the top-level rtl file
// ----------------------------------------------------------------------------
`ifndef LINE_SEGMENT_INTERSECTION_TOP_MACROS_SVH
`define LINE_SEGMENT_INTERSECTION_TOP_MACROS_SVH

// immediate implication checked at every clock edge outside reset
`define LSI_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the next cycle
`define LSI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/lsi_pkg.sv @@
// ----------------------------------------------------------------------------
// lsi_pkg
// shared constants of the segment intersection block
// ----------------------------------------------------------------------------
package lsi_pkg;
  localparam int CoordW        = 24;
  // fraction bits of a coordinate; the ratio has no unit, so no effect
  localparam int CoordFracBits = 8;
endpackage

@@ hw/rtl/lsi_stream_if.sv @@
// ----------------------------------------------------------------------------
// lsi_stream_if
// valid/ready channel with a generic payload
// ----------------------------------------------------------------------------
interface lsi_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/lsi_div_cell.sv @@
// ----------------------------------------------------------------------------
// lsi_div_cell
// one restoring division step plus pass-along of the item payload
// ----------------------------------------------------------------------------
module lsi_div_cell #(
  parameter int DW = 64,
  parameter int QW = 16,
  parameter int PW = 100
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  logic [DW-1:0] in_rem,
  input  logic [DW-1:0] in_den,
  input  logic [QW-1:0] in_q,
  input  logic [PW-1:0] in_pay,
  output logic          vld,
  output logic [DW-1:0] rem,
  output logic [DW-1:0] den,
  output logic [QW-1:0] q,
  output logic [PW-1:0] pay
);
  logic [DW:0] shifted;
  logic [DW:0] diff;
  logic        take;

  // shift in a zero, try subtracting the divisor
  always_comb begin
    shifted = {in_rem, 1'b0};
    diff    = shifted - {1'b0, in_den};
    take    = !diff[DW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem <= take ? diff[DW-1:0] : shifted[DW-1:0];
      den <= in_den;
      q   <= {in_q[QW-2:0], take};
      pay <= in_pay;
    end
  end
endmodule

@@ hw/rtl/line_segment_intersection_top.sv @@
// ----------------------------------------------------------------------------
// line_segment_intersection_top
// intersection of segment AB with the line through C and D
// ----------------------------------------------------------------------------
// Fully pipelined: one beat in and one beat out per cycle while output beats are
// taken. Differences and products take two stages, the
// cross products with the sign and range check one (which also decides the
// integer bit of the ratio), the ratio fraction is a chain of RATIO_FRAC_BITS
// division cells (one quotient bit each), and scaling along AB takes two
// stages. The whole pipe stalls only when a valid output beat is not taken.
`include "line_segment_intersection_top_macros.svh"

module line_segment_intersection_top #(
  parameter int RATIO_FRAC_BITS = 16
) (
  input logic clk,
  input logic rst,
  lsi_stream_if.sink   in_ch,
  lsi_stream_if.source out_ch
);
  localparam int CW = lsi_pkg::CoordW;
  localparam int DW = CW + 1;            // coordinate differences
  localparam int NW = 2 * DW + 1;        // cross products
  localparam int QW = RATIO_FRAC_BITS + 1;
  localparam int PW = 4 * CW;            // ax ay bx by carried along
  localparam int NS = RATIO_FRAC_BITS;

  logic en;
  logic s1_vld, s2_vld, s3_vld, s5_vld, s6_vld;

  // pipe advances when output slot is free or taken
  assign en = !s6_vld || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: differences
  logic signed [DW-1:0] d_ayc, d_dxc, d_axc, d_dyc, d_bxa, d_bya;
  logic [PW-1:0]        s1_pay;
  always_ff @(posedge clk) begin
    if (en) begin
      d_ayc  <= DW'($signed(in_ch.data.ay)) - DW'($signed(in_ch.data.cy));
      d_dxc  <= DW'($signed(in_ch.data.dx)) - DW'($signed(in_ch.data.cx));
      d_axc  <= DW'($signed(in_ch.data.ax)) - DW'($signed(in_ch.data.cx));
      d_dyc  <= DW'($signed(in_ch.data.dy)) - DW'($signed(in_ch.data.cy));
      d_bxa  <= DW'($signed(in_ch.data.bx)) - DW'($signed(in_ch.data.ax));
      d_bya  <= DW'($signed(in_ch.data.by)) - DW'($signed(in_ch.data.ay));
      s1_pay <= {in_ch.data.ax, in_ch.data.ay, in_ch.data.bx, in_ch.data.by};
    end
  end

  // stage 2: four products
  logic signed [2*DW-1:0] p0, p1, p2, p3;
  logic [PW-1:0]          s2_pay;
  always_ff @(posedge clk) begin
    if (en) begin
      p0     <= d_ayc * d_dxc;
      p1     <= d_axc * d_dyc;
      p2     <= d_bxa * d_dyc;
      p3     <= d_bya * d_dxc;
      s2_pay <= s1_pay;
    end
  end

  // stage 3: cross products, magnitudes and range check
  logic signed [NW-1:0] num_c, den_c;
  logic [NW-1:0]        an_c, ad_c;
  logic                 ok_c;
  logic                 eq_c;
  always_comb begin
    num_c = NW'(p0) - NW'(p1);
    den_c = NW'(p2) - NW'(p3);
    an_c  = num_c[NW-1] ? NW'(-num_c) : NW'(num_c);
    ad_c  = den_c[NW-1] ? NW'(-den_c) : NW'(den_c);
    ok_c  = (num_c != '0) && (den_c != '0) && (num_c[NW-1] == den_c[NW-1])
            && (an_c <= ad_c);
    eq_c  = (an_c == ad_c);
  end

  logic [NW-1:0] s3_an, s3_ad;
  logic          s3_ok;
  logic          s3_eq;
  logic [PW-1:0] s3_pay;
  always_ff @(posedge clk) begin
    if (en) begin
      s3_an  <= an_c;
      s3_ad  <= ad_c;
      s3_ok  <= ok_c;
      s3_eq  <= eq_c;
      s3_pay <= s2_pay;
    end
  end

  // division chain, one fraction bit per cell; integer bit set when an == ad
  logic [NS:0]        c_vld;
  logic [NW-1:0]      c_rem [NS+1];
  logic [NW-1:0]      c_den [NS+1];
  logic [QW-1:0]      c_q   [NS+1];
  logic [PW:0]        c_pay [NS+1];

  assign c_vld[0] = s3_vld;
  assign c_rem[0] = s3_eq ? '0 : s3_an;
  assign c_den[0] = s3_ad;
  assign c_q[0]   = {{(QW-1){1'b0}}, s3_eq};
  assign c_pay[0] = {s3_ok, s3_pay};

  for (genvar i = 0; i < NS; i++) begin : g_cell
    lsi_div_cell #(.DW(NW), .QW(QW), .PW(PW + 1)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .in_vld (c_vld[i]),
      .in_rem (c_rem[i]),
      .in_den (c_den[i]),
      .in_q   (c_q[i]),
      .in_pay (c_pay[i]),
      .vld    (c_vld[i+1]),
      .rem    (c_rem[i+1]),
      .den    (c_den[i+1]),
      .q      (c_q[i+1]),
      .pay    (c_pay[i+1])
    );
  end

  assign s5_vld = c_vld[NS];
  logic [PW-1:0] s5_pay;
  logic          s5_ok;
  assign {s5_ok, s5_pay} = c_pay[NS];

  // stage 6a: products r*(B-A)
  logic signed [CW-1:0]   e_ax, e_ay, e_bx, e_by;
  logic [RATIO_FRAC_BITS:0] r_q;
  assign {e_ax, e_ay, e_bx, e_by} = s5_pay;
  assign r_q = c_q[NS][RATIO_FRAC_BITS:0];

  localparam int MW = DW + RATIO_FRAC_BITS + 2;
  logic signed [MW-1:0]   mx, my;
  logic signed [CW-1:0]   m_ax, m_ay;
  logic                   m_ok;
  logic                   s4_vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (en) begin
      s4_vld <= s5_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mx   <= $signed({1'b0, r_q}) * (DW'(e_bx) - DW'(e_ax));
      my   <= $signed({1'b0, r_q}) * (DW'(e_by) - DW'(e_ay));
      m_ax <= e_ax;
      m_ay <= e_ay;
      m_ok <= s5_ok;
    end
  end

  // stage 6b: add offset to A, zero on miss
  logic          hit_r;
  logic [CW-1:0] px_r, py_r;
  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else if (en) begin
      s6_vld <= s4_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= m_ok;
      px_r  <= m_ok ? CW'(m_ax + CW'(mx >>> RATIO_FRAC_BITS)) : '0;
      py_r  <= m_ok ? CW'(m_ay + CW'(my >>> RATIO_FRAC_BITS)) : '0;
    end
  end

  assign out_ch.valid   = s6_vld;
  assign out_ch.data.hit = hit_r;
  assign out_ch.data.px = px_r;
  assign out_ch.data.py = py_r;

  // front valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_ch.valid;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
    end
  end

  `LSI_ASSERT_IMP(a_stall_hold, clk, rst, out_ch.valid && !out_ch.ready, !in_ch.ready)
  `LSI_ASSERT_NEXT(a_out_hold, clk, rst, out_ch.valid && !out_ch.ready, out_ch.valid)
  `LSI_ASSERT_IMP(a_miss_zero, clk, rst, out_ch.valid && !out_ch.data.hit, out_ch.data.px == '0 && out_ch.data.py == '0)
endmodule

@@ tb/lsi_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// lsi_tb_pkg
// beat layouts shared by the segment intersection testbench files
// ----------------------------------------------------------------------------
package lsi_tb_pkg;
  typedef logic signed [lsi_pkg::CoordW-1:0] coord_t;

  // four points per input beat, A first
  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t cx;
    coord_t cy;
    coord_t dx;
    coord_t dy;
  } seg_pair_t;

  // one crossing per output beat
  typedef struct packed {
    logic   hit;
    coord_t px;
    coord_t py;
  } crossing_t;
endpackage

@@ tb/lsi_crossing_checker.sv @@
// ----------------------------------------------------------------------------
// lsi_crossing_checker
// watches both channels, predicts each crossing and compares it
// ----------------------------------------------------------------------------
// Every accepted segment pair queues one predicted crossing. Each accepted
// output beat is compared field by field against the oldest prediction.
module lsi_crossing_checker #(
  parameter int RATIO_BITS = 16
) (
  input  logic  clk,
  input  logic  rst,
  lsi_stream_if in_ch,
  lsi_stream_if out_ch,
  output int    fails,
  output int    pending
);
  lsi_tb_pkg::crossing_t crossings_due[$];

  // crossing of segment AB with the line through C and D, ratio truncated to RATIO_BITS fraction bits
  function automatic lsi_tb_pkg::crossing_t predict_crossing(lsi_tb_pkg::seg_pair_t s);
    logic signed [63:0]    num, den, off_x, off_y;
    logic        [63:0]    mag_num, mag_den;
    logic        [95:0]    quot;
    logic signed [63:0]    ratio;
    lsi_tb_pkg::crossing_t c;
    num = (64'(s.ay) - 64'(s.cy)) * (64'(s.dx) - 64'(s.cx))
        - (64'(s.ax) - 64'(s.cx)) * (64'(s.dy) - 64'(s.cy));
    den = (64'(s.bx) - 64'(s.ax)) * (64'(s.dy) - 64'(s.cy))
        - (64'(s.by) - 64'(s.ay)) * (64'(s.dx) - 64'(s.cx));
    c = '0;
    if (num == 0 || den == 0) return c;
    if (num[63] != den[63]) return c;
    mag_num = num[63] ? -num : num;
    mag_den = den[63] ? -den : den;
    if (mag_num > mag_den) return c;
    quot  = (96'(mag_num) << RATIO_BITS) / 96'(mag_den);
    ratio = $signed({1'b0, quot[62:0]});
    off_x = (ratio * (64'(s.bx) - 64'(s.ax))) >>> RATIO_BITS;
    off_y = (ratio * (64'(s.by) - 64'(s.ay))) >>> RATIO_BITS;
    c.hit = 1'b1;
    c.px  = lsi_tb_pkg::coord_t'(64'(s.ax) + off_x);
    c.py  = lsi_tb_pkg::coord_t'(64'(s.ay) + off_y);
    return c;
  endfunction

  // queue on input beats, compare on output beats
  always @(posedge clk) begin
    lsi_tb_pkg::crossing_t want, got;
    if (rst) begin
      fails <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        crossings_due.push_back(predict_crossing(lsi_tb_pkg::seg_pair_t'(in_ch.data)));
      if (out_ch.valid && out_ch.ready) begin
        got = lsi_tb_pkg::crossing_t'(out_ch.data);
        if (crossings_due.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual hit=%0b px=%0d py=%0d",
                   $time, got.hit, got.px, got.py);
          fails <= fails + 1;
        end else begin
          want = crossings_due.pop_front();
          if (want.hit !== got.hit || want.px !== got.px || want.py !== got.py) begin
            $display("%0t: expected hit=%0b px=%0d py=%0d, actual hit=%0b px=%0d py=%0d",
                     $time, want.hit, want.px, want.py, got.hit, got.px, got.py);
            fails <= fails + 1;
          end
        end
      end
    end
    pending <= crossings_due.size();
  end
endmodule

@@ tb/tb_line_segment_intersection_top.sv @@
// ----------------------------------------------------------------------------
// tb_line_segment_intersection_top
// stimulus and verdict for the segment intersection block
// ----------------------------------------------------------------------------
// Directed corner pairs first, then random pairs, mostly built to cross the line of AB.
// Both sides idle in random bursts; once the output is held off long enough
// to fill the pipe, and once the input waits for the pipe to drain.
module tb_line_segment_intersection_top;
  localparam int NumRandom = 1600;
  localparam int CalmTail  = 200;
  localparam int Latency   = 21;

  logic clk;
  logic rst;
  int   fails;
  int   pending;
  bit   sink_calm;
  bit   long_hold;

  lsi_stream_if #(.payload_t(lsi_tb_pkg::seg_pair_t)) in_ch ();
  lsi_stream_if #(.payload_t(lsi_tb_pkg::crossing_t)) out_ch ();

  line_segment_intersection_top u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lsi_crossing_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .fails   (fails),
    .pending (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // timeout
  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic lsi_tb_pkg::coord_t rand_coord(int span);
    return lsi_tb_pkg::coord_t'($urandom_range(2 * span) - span);
  endfunction

  function automatic lsi_tb_pkg::seg_pair_t make_pair(int ax, int ay, int bx, int by,
                                                      int cx, int cy, int dx, int dy);
    lsi_tb_pkg::seg_pair_t s;
    s = '{lsi_tb_pkg::coord_t'(ax), lsi_tb_pkg::coord_t'(ay),
          lsi_tb_pkg::coord_t'(bx), lsi_tb_pkg::coord_t'(by),
          lsi_tb_pkg::coord_t'(cx), lsi_tb_pkg::coord_t'(cy),
          lsi_tb_pkg::coord_t'(dx), lsi_tb_pkg::coord_t'(dy)};
    return s;
  endfunction

  // pair whose CD line crosses the line of AB at a chosen fraction, sometimes beyond A or B
  function automatic lsi_tb_pkg::seg_pair_t crossing_pair();
    lsi_tb_pkg::seg_pair_t s;
    int                    k;
    longint                px, py;
    s.ax = rand_coord(1 << 21);
    s.ay = rand_coord(1 << 21);
    s.bx = rand_coord(1 << 21);
    s.by = rand_coord(1 << 21);
    s.cx = rand_coord(1 << 21);
    s.cy = rand_coord(1 << 21);
    k    = $urandom_range(20) - 2;
    px   = s.ax + (longint'(s.bx) - s.ax) * k / 16;
    py   = s.ay + (longint'(s.by) - s.ay) * k / 16;
    s.dx = lsi_tb_pkg::coord_t'(2 * px - s.cx);
    s.dy = lsi_tb_pkg::coord_t'(2 * py - s.cy);
    return s;
  endfunction

  // small coordinates so parallel and degenerate pairs turn up
  function automatic lsi_tb_pkg::seg_pair_t small_pair();
    lsi_tb_pkg::seg_pair_t s;
    s = make_pair($urandom_range(6) - 3, $urandom_range(6) - 3,
                  $urandom_range(6) - 3, $urandom_range(6) - 3,
                  $urandom_range(6) - 3, $urandom_range(6) - 3,
                  $urandom_range(6) - 3, $urandom_range(6) - 3);
    return s;
  endfunction

  task automatic send_pair(lsi_tb_pkg::seg_pair_t s, bit may_idle);
    bit taken;
    if (may_idle && $urandom_range(3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= s;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end
  endtask

  // output side: random stall bursts, one long hold, none near the end
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        for (hold = 0; hold < 200; hold++) @(posedge clk);
        long_hold = 1'b0;
      end else if (!sink_calm && $urandom_range(3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(15, 1)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(15, 1)) @(posedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin
    lsi_tb_pkg::seg_pair_t directed[$];
    int                    sel;
    int                    waited;
    rst         = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    sink_calm   = 1'b0;
    long_hold   = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corners: zeros, extremes, parallel, touching A, t=1, t beyond AB
    directed.push_back('0);
    directed.push_back({8{24'h7fffff}});
    directed.push_back({8{24'h800000}});
    directed.push_back(make_pair(-8388608, -8388608, 8388607, 8388607,
                                 -8388608, 8388607, 8388607, -8388608));
    directed.push_back(make_pair(0, 0, 256, 0, 0, 256, 256, 256));
    directed.push_back(make_pair(0, 0, 256, 0, 0, 0, 0, 256));
    directed.push_back(make_pair(0, 0, 256, 0, 128, -256, 128, 256));
    directed.push_back(make_pair(0, 0, 256, 0, 256, -256, 256, 256));
    directed.push_back(make_pair(0, 0, 256, 0, 512, -256, 512, 256));
    directed.push_back(make_pair(0, 0, 256, 0, -128, -256, -128, 256));
    directed.push_back(make_pair(5, 5, 5, 5, 0, 0, 9, 9));
    directed.push_back(make_pair(0, 0, 768, 256, 100, -300, 100, 300));
    directed.push_back(make_pair(8388607, 0, -8388608, 0, 0, -8388608, 1, 8388607));
    directed.push_back(make_pair(-1, -1, 1, 1, 1, -1, -1, 1));
    directed.push_back(make_pair(0, 0, 3, 0, 1, -7, 1, 5));
    foreach (directed[i]) send_pair(directed[i], 1'b0);

    for (int n = 0; n < NumRandom; n++) begin
      if (n == 300) long_hold = 1'b1;
      if (n == 700) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if (n == NumRandom - CalmTail) sink_calm = 1'b1;
      sel = $urandom_range(99);
      if (sel < 60) send_pair(crossing_pair(), n < NumRandom - CalmTail);
      else if (sel < 75) send_pair(small_pair(), n < NumRandom - CalmTail);
      else send_pair(lsi_tb_pkg::seg_pair_t'({$urandom, $urandom, $urandom, $urandom,
                                              $urandom, $urandom}),
                     n < NumRandom - CalmTail);
    end
    in_ch.valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * Latency) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/lsi_pkg.sv
hw/rtl/lsi_stream_if.sv
hw/rtl/lsi_div_cell.sv
hw/rtl/line_segment_intersection_top.sv
tb/lsi_tb_pkg.sv
tb/lsi_crossing_checker.sv
tb/tb_line_segment_intersection_top.sv
